// ===== sv/e2cd_pkg.sv =====
// ----------------------------------------------------------------------------
// e2cd_pkg
// Shared constants, types and helper functions for the epoch to calendar
// date converter.
// ----------------------------------------------------------------------------
package e2cd_pkg;

	localparam logic [31:0] SECS_LEAP_YEAR   = 32'd31622400;
	localparam logic [31:0] SECS_COMMON_YEAR = 32'd31536000;
	localparam logic [31:0] SECS_MONTH_31    = 32'd2678400;
	localparam logic [31:0] SECS_MONTH_30    = 32'd2592000;
	localparam logic [31:0] SECS_FEB_LEAP    = 32'd2505600;
	localparam logic [31:0] SECS_FEB_COMMON  = 32'd2419200;
	localparam logic [31:0] SECS_DAY         = 32'd86400;
	localparam logic [31:0] SECS_HOUR        = 32'd3600;
	localparam logic [31:0] SECS_MINUTE      = 32'd60;

	localparam logic [11:0] BASE_YEAR     = 12'd1970;
	// only century year in range that is not a leap year
	localparam logic [11:0] CENTURY_NOLEAP = 12'd2100;
	localparam logic [3:0]  FIRST_MONTH   = 4'd1;
	localparam logic [9:0]  MS_MAX        = 10'd999;

	// quotient widths
	localparam int DAY_QBITS  = 5;
	localparam int HOUR_QBITS = 5;
	localparam int MIN_QBITS  = 6;
	localparam int MS_QBITS   = 11;

	// floor(x / d) as (x * ceil(2^s / d)) >> s, exact over each operand range;
	// the power-of-two part of each divisor is shifted off x first
	localparam logic [14:0] DAY_RECIP  = 15'd24856; // 2^24 / 675, x = rem >> 7
	localparam logic [12:0] HOUR_RECIP = 13'd4661;  // 2^20 / 225, x = rem >> 4
	localparam logic [10:0] MIN_RECIP  = 11'd1093;  // 2^14 / 15,  x = rem >> 2
	localparam logic [16:0] MS_RECIP   = 17'd67109; // 2^23 / 125, x = usec >> 3
	localparam int DAY_RSH  = 24;
	localparam int HOUR_RSH = 20;
	localparam int MIN_RSH  = 14;
	localparam int MS_RSH   = 23;

	localparam logic [3:0] MON_FEB = 4'd2;
	localparam logic [3:0] MON_APR = 4'd4;
	localparam logic [3:0] MON_JUN = 4'd6;
	localparam logic [3:0] MON_SEP = 4'd9;
	localparam logic [3:0] MON_NOV = 4'd11;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_YEAR   = 11'b000_0000_0010,
		ST_MONTH  = 11'b000_0000_0100,
		ST_DAY_Q  = 11'b000_0000_1000,
		ST_DAY_R  = 11'b000_0001_0000,
		ST_HOUR_Q = 11'b000_0010_0000,
		ST_HOUR_R = 11'b000_0100_0000,
		ST_MIN_Q  = 11'b000_1000_0000,
		ST_MIN_R  = 11'b001_0000_0000,
		ST_MSEC   = 11'b010_0000_0000,
		ST_DONE   = 11'b100_0000_0000
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_YEAR,
		OP_MONTH,
		OP_DAY_Q,
		OP_DAY_R,
		OP_HOUR_Q,
		OP_HOUR_R,
		OP_MIN_Q,
		OP_MIN_R,
		OP_MSEC
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic ge;
	} sts_t;

	// year stays within 1970..2106, so the 400-year rule reduces to one exception
	function automatic logic is_leap(input logic [11:0] y);
		return (y[1:0] == 2'b00) && (y != CENTURY_NOLEAP);
	endfunction

	function automatic logic [31:0] month_len(input logic [3:0] m, input logic leap);
		logic [31:0] len;
		len = SECS_MONTH_31;
		if (m == MON_FEB)
			len = leap ? SECS_FEB_LEAP : SECS_FEB_COMMON;
		else if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV)
			len = SECS_MONTH_30;
		return len;
	endfunction

endpackage

// ===== sv/e2cd_ctrl.sv =====
// ----------------------------------------------------------------------------
// e2cd_ctrl
// Sequencer: walks the year and month peeling loops, then the quotient and
// remainder steps for day, hour and minute, and the millisecond step.
// ----------------------------------------------------------------------------
module e2cd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  e2cd_pkg::sts_t sts,
	output e2cd_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);
	import e2cd_pkg::*;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start)
						state_q <= ST_YEAR;
				end
				ST_YEAR: begin
					if (!sts.ge)
						state_q <= ST_MONTH;
				end
				ST_MONTH: begin
					if (!sts.ge)
						state_q <= ST_DAY_Q;
				end
				ST_DAY_Q:  state_q <= ST_DAY_R;
				ST_DAY_R:  state_q <= ST_HOUR_Q;
				ST_HOUR_Q: state_q <= ST_HOUR_R;
				ST_HOUR_R: state_q <= ST_MIN_Q;
				ST_MIN_Q:  state_q <= ST_MIN_R;
				ST_MIN_R:  state_q <= ST_MSEC;
				ST_MSEC:   state_q <= ST_DONE;
				ST_DONE:   state_q <= ST_IDLE;
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE:   cmd.op = start ? OP_LOAD : OP_NONE;
			ST_YEAR:   cmd.op = OP_YEAR;
			ST_MONTH:  cmd.op = OP_MONTH;
			ST_DAY_Q:  cmd.op = OP_DAY_Q;
			ST_DAY_R:  cmd.op = OP_DAY_R;
			ST_HOUR_Q: cmd.op = OP_HOUR_Q;
			ST_HOUR_R: cmd.op = OP_HOUR_R;
			ST_MIN_Q:  cmd.op = OP_MIN_Q;
			ST_MIN_R:  cmd.op = OP_MIN_R;
			ST_MSEC:   cmd.op = OP_MSEC;
			default:   cmd.op = OP_NONE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted item did not start the sequence");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("done strobe longer than one cycle");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_msec_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_MSEC) |=> done)
		else $error("millisecond step not followed by done");

endmodule

// ===== sv/e2cd_dp.sv =====
// ----------------------------------------------------------------------------
// e2cd_dp
// Datapath: zone offset register, offset and clamp at load, one shared
// compare-and-subtract unit for the peeling loops and the remainders, and
// reciprocal multiplies for the day, hour, minute and millisecond quotients.
// ----------------------------------------------------------------------------
module e2cd_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [4:0]     cfg_wdata,
	input  e2cd_pkg::cmd_t cmd,
	output e2cd_pkg::sts_t sts,
	input  logic [31:0]    epoch_seconds,
	input  logic [19:0]    microseconds,
	output logic [11:0]    year,
	output logic [3:0]     month,
	output logic [4:0]     day,
	output logic [4:0]     hour,
	output logic [5:0]     minute,
	output logic [5:0]     second,
	output logic [9:0]     millisecond
);
	import e2cd_pkg::*;

	logic signed [4:0]  zone_q;
	logic [31:0]        rem_q;
	logic [19:0]        usec_q;
	logic [11:0]        year_q;
	logic [3:0]         month_q;
	logic [DAY_QBITS-1:0]  day_q;
	logic [HOUR_QBITS-1:0] hour_q;
	logic [MIN_QBITS-1:0]  min_q;
	logic [MS_QBITS-1:0]   ms_q;

	logic signed [33:0] adj;
	logic [31:0]        adj_sat;
	logic [31:0]        opnd;
	logic [32:0]        diff;

	logic [DAY_QBITS-1:0]  day_quo;
	logic [HOUR_QBITS-1:0] hour_quo;
	logic [MIN_QBITS-1:0]  min_quo;
	logic [MS_QBITS-1:0]   ms_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			zone_q <= '0;
		else if (cfg_we)
			zone_q <= cfg_wdata;
	end

	// offset applied first, clamped to the unsigned 32-bit range
	always_comb begin
		adj = $signed({2'b00, epoch_seconds})
			+ 34'(zone_q) * $signed({2'b00, SECS_HOUR});
		if (adj[33])
			adj_sat = '0;
		else if (adj[32])
			adj_sat = '1;
		else
			adj_sat = adj[31:0];
	end

	// quotients; rem_q is below one month, one day or one hour at the step that uses it
	always_comb begin
		day_quo  = DAY_QBITS'(({15'd0, rem_q[21:7]} * {15'd0, DAY_RECIP}) >> DAY_RSH);
		hour_quo = HOUR_QBITS'(({13'd0, rem_q[16:4]} * {13'd0, HOUR_RECIP}) >> HOUR_RSH);
		min_quo  = MIN_QBITS'(({11'd0, rem_q[11:2]} * {10'd0, MIN_RECIP}) >> MIN_RSH);
		ms_quo   = MS_QBITS'(({17'd0, usec_q[19:3]} * {17'd0, MS_RECIP}) >> MS_RSH);
	end

	always_comb begin
		case (cmd.op)
			OP_YEAR:   opnd = is_leap(year_q) ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
			OP_MONTH:  opnd = month_len(month_q, is_leap(year_q));
			OP_DAY_R:  opnd = {27'd0, day_q} * SECS_DAY;
			OP_HOUR_R: opnd = {27'd0, hour_q} * SECS_HOUR;
			OP_MIN_R:  opnd = {26'd0, min_q} * SECS_MINUTE;
			default:   opnd = '0;
		endcase
		diff   = {1'b0, rem_q} - {1'b0, opnd};
		sts.ge = !diff[32];
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				rem_q   <= adj_sat;
				usec_q  <= microseconds;
				year_q  <= BASE_YEAR;
				month_q <= FIRST_MONTH;
				day_q   <= '0;
				hour_q  <= '0;
				min_q   <= '0;
				ms_q    <= '0;
			end
			OP_YEAR: begin
				if (sts.ge) begin
					rem_q  <= diff[31:0];
					year_q <= year_q + 1'b1;
				end
			end
			OP_MONTH: begin
				if (sts.ge) begin
					rem_q   <= diff[31:0];
					month_q <= month_q + 1'b1;
				end
			end
			OP_DAY_Q:  day_q  <= day_quo;
			OP_HOUR_Q: hour_q <= hour_quo;
			OP_MIN_Q:  min_q  <= min_quo;
			OP_DAY_R, OP_HOUR_R, OP_MIN_R: begin
				rem_q <= diff[31:0];
			end
			OP_MSEC:   ms_q   <= ms_quo;
			default: begin
			end
		endcase
	end

	assign year        = year_q;
	assign month       = month_q;
	assign day         = day_q + 1'b1;
	assign hour        = hour_q;
	assign minute      = min_q;
	assign second      = rem_q[5:0];
	// over-range microsecond input saturates here
	assign millisecond = (ms_q > MS_QBITS'(MS_MAX)) ? MS_MAX : ms_q[9:0];

endmodule

// ===== sv/epoch_to_calendar_date.sv =====
// ----------------------------------------------------------------------------
// epoch_to_calendar_date
// Converts Unix epoch seconds plus microseconds to a Gregorian date and time
// in a configured whole-hour zone.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand over an item; busy stays high until
// the result has been shown. The result appears on the output ports for one
// cycle, flagged by done, and must be captured then: there is no holding it.
// Each item runs the year and month loops on the shared compare-and-subtract
// unit (one step per year or month peeled plus the step that stops the
// loop), then, for each of day, hour and minute, a reciprocal multiply and
// a subtract of the multiple, then the millisecond step and the done state.
// The next item can be taken in the cycle after done. The zone offset
// (cfg_wdata, signed hours) may only be written while busy is low.
module epoch_to_calendar_date (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] epoch_seconds,
	input  logic [19:0] microseconds,
	output logic        done,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second,
	output logic [9:0]  millisecond
);
	import e2cd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	e2cd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	e2cd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.cmd           (cmd),
		.sts           (sts),
		.epoch_seconds (epoch_seconds),
		.microseconds  (microseconds),
		.year          (year),
		.month         (month),
		.day           (day),
		.hour          (hour),
		.minute        (minute),
		.second        (second),
		.millisecond   (millisecond)
	);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives Unix timestamps into the epoch to calendar date converter under a
// series of zone offsets. A scoreboard works out each calendar date from the
// offset seconds and checks every done strobe against it in order.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic [11:0] yr;
	logic [3:0]  mon;
	logic [4:0]  dom;
	logic [4:0]  hr;
	logic [5:0]  mins;
	logic [5:0]  secs;
	logic [9:0]  msec;
} date_t;

class date_scoreboard;
	localparam longint unsigned LEAP_YEAR_SECS   = 31622400;
	localparam longint unsigned COMMON_YEAR_SECS = 31536000;
	localparam longint unsigned DAY_SECS         = 86400;
	localparam longint unsigned HOUR_SECS        = 3600;
	localparam longint          MAX_SECS         = 64'hFFFF_FFFF;

	logic signed [4:0] zone;
	date_t             expected_dates[$];
	int                errors;

	function new();
		zone = '0;
		errors = 0;
	endfunction

	static function bit leap_year(int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	static function longint unsigned year_secs(int unsigned y);
		return leap_year(y) ? LEAP_YEAR_SECS : COMMON_YEAR_SECS;
	endfunction

	static function longint unsigned month_secs(int unsigned m, int unsigned y);
		case (m)
			2: return leap_year(y) ? 64'd2505600 : 64'd2419200;
			4, 6, 9, 11: return 64'd2592000;
			default: return 64'd2678400;
		endcase
	endfunction

	// seconds from the epoch to the first instant of a given month
	static function longint month_start(int unsigned y, int unsigned m);
		longint total;
		total = 0;
		for (int unsigned i = 1970; i < y; i++)
			total += year_secs(i);
		for (int unsigned i = 1; i < m; i++)
			total += month_secs(i, y);
		return total;
	endfunction

	function void set_zone(logic signed [4:0] z);
		zone = z;
	endfunction

	function date_t to_calendar(logic [31:0] epoch, logic [19:0] usec);
		int                zh;
		longint            adj;
		longint unsigned   rem;
		int unsigned       y, m, ms;
		date_t             d;
		zh = int'(zone);
		adj = longint'({32'd0, epoch}) + longint'(zh) * longint'(HOUR_SECS);
		if (adj < 0)
			adj = 0;
		if (adj > MAX_SECS)
			adj = MAX_SECS;
		rem = adj;
		y = 1970;
		while (rem >= year_secs(y)) begin
			rem -= year_secs(y);
			y++;
		end
		m = 1;
		while (rem >= month_secs(m, y)) begin
			rem -= month_secs(m, y);
			m++;
		end
		ms = usec / 1000;
		if (ms > 999)
			ms = 999;
		d.yr = 12'(y);
		d.mon = 4'(m);
		d.dom = 5'(rem / DAY_SECS + 1);
		rem = rem % DAY_SECS;
		d.hr = 5'(rem / HOUR_SECS);
		rem = rem % HOUR_SECS;
		d.mins = 6'(rem / 60);
		d.secs = 6'(rem % 60);
		d.msec = 10'(ms);
		return d;
	endfunction

	function void note_item(logic [31:0] epoch, logic [19:0] usec);
		expected_dates.push_back(to_calendar(epoch, usec));
	endfunction

	function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
			errors++;
		end
	endfunction

	function void check_result(date_t got);
		date_t exp_d;
		if (expected_dates.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %p", $time, got);
			errors++;
			return;
		end
		exp_d = expected_dates.pop_front();
		compare_field("year", 32'(exp_d.yr), 32'(got.yr));
		compare_field("month", 32'(exp_d.mon), 32'(got.mon));
		compare_field("day", 32'(exp_d.dom), 32'(got.dom));
		compare_field("hour", 32'(exp_d.hr), 32'(got.hr));
		compare_field("minute", 32'(exp_d.mins), 32'(got.mins));
		compare_field("second", 32'(exp_d.secs), 32'(got.secs));
		compare_field("millisecond", 32'(exp_d.msec), 32'(got.msec));
	endfunction

	function int outstanding();
		return expected_dates.size();
	endfunction

	function void check_drained();
		foreach (expected_dates[i]) begin
			$display("%0t: missing result, expected %p, actual none", $time, expected_dates[i]);
			errors++;
		end
	endfunction
endclass

module tb_top;

	localparam int STALL_LIMIT  = 5000;
	localparam int PHASE_ITEMS  = 150;
	localparam int NUM_PHASES   = 7;
	localparam int TAIL_CYCLES  = 200;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [4:0]  cfg_wdata;
	logic        start;
	logic        busy;
	logic [31:0] epoch_seconds;
	logic [19:0] microseconds;
	logic        done;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic [9:0]  millisecond;

	date_scoreboard sb = new();
	int             idle_pct;
	int             stall_cycles;

	epoch_to_calendar_date dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.start         (start),
		.busy          (busy),
		.epoch_seconds (epoch_seconds),
		.microseconds  (microseconds),
		.done          (done),
		.year          (year),
		.month         (month),
		.day           (day),
		.hour          (hour),
		.minute        (minute),
		.second        (second),
		.millisecond   (millisecond)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result({year, month, day, hour, minute, second, millisecond});
	end

	// no item in and no result out for too long means the block is hung
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				stall_cycles = 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: timeout, no progress for %0d cycles", $time, STALL_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end else begin
				stall_cycles++;
			end
		end
	end

	// called at a falling edge; returns at the falling edge after the item is taken
	task automatic send_item(input logic [31:0] s, input logic [19:0] us);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 180)) @(negedge clk);
		end
		start = 1'b1;
		epoch_seconds = s;
		microseconds = us;
		do
			@(posedge clk);
		while (busy);
		sb.note_item(s, us);
		@(negedge clk);
	endtask

	// wait for every expected date, then load a new zone offset
	task automatic drain_and_set_zone(input logic signed [4:0] z);
		start = 1'b0;
		while (sb.outstanding() != 0 || busy)
			@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = z;
		sb.set_zone(z);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [31:0] pick_epoch();
		longint t;
		case ($urandom_range(9))
			5, 6, 7: begin
				// straddle a month boundary somewhere in range
				t = sb.month_start($urandom_range(1970, 2106), $urandom_range(1, 12));
				t = t + $urandom_range(0, 7200) - 3600;
				if (t < 0)
					t = 0;
				if (t > 64'hFFFF_FFFF)
					t = 64'hFFFF_FFFF;
				return t[31:0];
			end
			8: return $urandom_range(0, 60000);
			9: return 32'hFFFF_FFFF - $urandom_range(0, 60000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [19:0] pick_usec();
		if ($urandom_range(9) == 0)
			return 20'($urandom_range(0, 20'hFFFFF));
		return 20'($urandom_range(0, 999999));
	endfunction

	initial begin
		logic signed [4:0] zones [NUM_PHASES];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		start = 1'b0;
		epoch_seconds = '0;
		microseconds = '0;
		idle_pct = 0;
		stall_cycles = 0;
		zones = '{5'sd0, -5'sd16, 5'sd15, -5'sd12, 5'sd14, 5'sd0, 5'sd0};
		zones[5] = 5'($urandom_range(0, 31));
		zones[6] = 5'($urandom_range(0, 31));
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: epoch ends, leap days, century non-leap, ms saturation
		drain_and_set_zone(5'sd0);
		send_item(32'd0, 20'd0);
		send_item(32'd1, 20'd999);
		send_item(32'd59, 20'd1000);
		send_item(32'd86399, 20'd999999);
		send_item(32'd94694399, 20'hFFFFF);
		send_item(32'd68169600, 20'd500000);
		send_item(32'd946684799, 20'd0);
		send_item(32'd946684800, 20'd1);
		send_item(32'd951868799, 20'd123456);
		send_item(32'd4102444799, 20'd0);
		send_item(32'd4107456000, 20'd0);
		send_item(32'd4107542400, 20'd0);
		send_item(32'hFFFF_FFFF, 20'd999999);
		send_item(32'h8000_0000, 20'd0);

		// offset clamps at zero and at the top
		drain_and_set_zone(-5'sd16);
		send_item(32'd0, 20'd0);
		send_item(32'd57599, 20'd0);
		send_item(32'd57600, 20'd0);
		send_item(32'hFFFF_FFFF, 20'd0);
		drain_and_set_zone(5'sd15);
		send_item(32'd0, 20'd0);
		send_item(32'hFFFF_2D0F, 20'd0);
		send_item(32'hFFFF_2D10, 20'd0);
		send_item(32'hFFFF_FFFF, 20'd0);

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_and_set_zone(zones[p]);
			idle_pct = (p == 3) ? 0 : 10;
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_item(pick_epoch(), pick_usec());
		end

		start = 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		sb.check_drained();
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== epoch_to_calendar_date.f =====
sv/e2cd_pkg.sv
sv/e2cd_ctrl.sv
sv/e2cd_dp.sv
sv/epoch_to_calendar_date.sv
tb/tb_top.sv
